@@ sv/q32vs_pkg.sv @@
package q32vs_pkg;

   // Word and register field widths
   localparam int SAMPLE_W   = 32;
   localparam int VOLUME_W   = 7;
   localparam int BYTES_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Default gain precision
   localparam int FRACTION_BITS_DEF = 32;

   // Volume curve
   localparam int unsigned FULL_PERCENT = 100;
   localparam int unsigned PERCENT_SQ   = 10000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_VOLUME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MUTE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BYTES  = 2'd2;

   // Sample width codes
   localparam logic [BYTES_W-1:0] BYTES_ONE   = 3'd1;
   localparam logic [BYTES_W-1:0] BYTES_TWO   = 3'd2;
   localparam logic [BYTES_W-1:0] BYTES_THREE = 3'd3;
   localparam logic [BYTES_W-1:0] BYTES_FOUR  = 3'd4;

   // Reset values
   localparam logic [VOLUME_W-1:0] VOLUME_RST = VOLUME_W'(FULL_PERCENT);
   localparam logic                MUTE_RST   = 1'b0;
   localparam logic [BYTES_W-1:0]  BYTES_RST  = BYTES_TWO;

endpackage

@@ sv/q32vs_intf.sv @@
interface q32vs_req_if import q32vs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_in;
   logic                last_in;

   modport source (output valid, output sample_in, output last_in, input ready);
   modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface q32vs_rsp_if import q32vs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_out;
   logic                last_out;

   modport source (output valid, output sample_out, output last_out, input ready);
   modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

interface q32vs_csr_if import q32vs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/q32_quadratic_volume_scaler_core.sv @@
// Pipeline: an accepted word is held in stage 1, then in the result register.
// Throughput: one word per cycle unless rsp_chan stalls; the input-to-result
//   register path is one signed sample-by-gain multiply plus a rounding add.
// Reset (synchronous, active high) empties both pipeline stages and restores
//   volume 100, unmuted, two-byte samples; the gain register resets to unity.
module q32_quadratic_volume_scaler_core
   import q32vs_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   q32vs_req_if.sink     req_chan,
   q32vs_rsp_if.source   rsp_chan,
   q32vs_csr_if.sink     csr_chan
);

   // Gain is unsigned fixed point with one integer bit, so unity (2^F) fits.
   localparam int GAIN_W = FRACTION_BITS + 1;
   // Signed sample times gain (zero-extended to signed), full precision.
   localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
   localparam logic [PROD_W-1:0] ROUND_BIAS =
      {{(PROD_W-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);

   typedef logic [GAIN_W-1:0] gain_type;
   typedef gain_type          gain_table_type [FULL_PERCENT+1];

   // floor(v*v*2^F/10000) for v = 0..100; entry 0 is zero, entry 100 is unity.
   function automatic gain_table_type build_gain_table();
      gain_table_type tbl;
      logic [63:0]    num;
      for (int v = 0; v <= int'(FULL_PERCENT); v++) begin
         num    = 64'(v * v) << FRACTION_BITS;
         tbl[v] = GAIN_W'(num / PERCENT_SQ);
      end
      return tbl;
   endfunction

   localparam gain_table_type GAIN_TABLE = build_gain_table();

   // ---------------------------------------------------------------------------
   // Configuration registers. The gain is refreshed on the write itself, so a
   // word accepted the very next cycle already sees the new setting.
   // ---------------------------------------------------------------------------
   logic [VOLUME_W-1:0] volume_ff, volume_in;
   logic                mute_ff, mute_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   gain_type            gain_ff, gain_in;
   logic                csr_write;
   logic [VOLUME_W-1:0] csr_volume;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;
   assign csr_volume     = csr_chan.data[VOLUME_W-1:0];

   always_comb begin
      volume_in = volume_ff;
      mute_in   = mute_ff;
      bytes_in  = bytes_ff;
      if (csr_write) begin
         case (csr_chan.index)
            REG_VOLUME: begin
               // saturate at full scale
               volume_in = (csr_volume > VOLUME_W'(FULL_PERCENT)) ?
                           VOLUME_W'(FULL_PERCENT) : csr_volume;
            end
            REG_MUTE:  mute_in  = csr_chan.data[0];
            REG_BYTES: bytes_in = csr_chan.data[BYTES_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
      gain_in = mute_in ? '0 : GAIN_TABLE[volume_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= VOLUME_RST;
         mute_ff   <= MUTE_RST;
         bytes_ff  <= BYTES_RST;
         gain_ff   <= GAIN_TABLE[VOLUME_RST];
      end else begin
         volume_ff <= volume_in;
         mute_ff   <= mute_in;
         bytes_ff  <= bytes_in;
         gain_ff   <= gain_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Handshake. Stage 1 holds the sign-extended sample, stage 2 is the output
   // register. Stage 1 refills whenever it empties into stage 2, so a stalled
   // result still leaves room for one more word.
   // ---------------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free;
   logic req_take;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: sign extension from the configured width. Unsupported width
   // codes pass the raw word through untouched.
   // ---------------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] s1_sample_ff, s1_sample_in;
   logic                       s1_last_ff;

   always_comb begin
      case (bytes_ff)
         BYTES_ONE:   s1_sample_in = SAMPLE_W'($signed(req_chan.sample_in[7:0]));
         BYTES_TWO:   s1_sample_in = SAMPLE_W'($signed(req_chan.sample_in[15:0]));
         BYTES_THREE: s1_sample_in = SAMPLE_W'($signed(req_chan.sample_in[23:0]));
         default:     s1_sample_in = $signed(req_chan.sample_in);
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff <= s1_sample_in;
         s1_last_ff   <= req_chan.last_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: sample * gain + half LSB, keep bits [F+31:F] (arithmetic shift),
   // then mask back to the sample width; unsupported codes pass stage 1 raw.
   // ---------------------------------------------------------------------------
   logic signed [PROD_W-1:0] sample_wide;
   logic signed [PROD_W-1:0] gain_wide;
   logic        [PROD_W-1:0] product;
   logic        [PROD_W-1:0] rounded;
   logic        [SAMPLE_W-1:0] scaled;
   logic        [SAMPLE_W-1:0] result_in;
   logic        [SAMPLE_W-1:0] result_ff;
   logic                       last_ff;

   assign sample_wide = PROD_W'(s1_sample_ff);
   assign gain_wide   = PROD_W'(gain_ff);
   assign product     = sample_wide * gain_wide;
   assign rounded     = product + ROUND_BIAS;
   assign scaled      = rounded[FRACTION_BITS +: SAMPLE_W];

   always_comb begin
      case (bytes_ff)
         BYTES_ONE:   result_in = {24'd0, scaled[7:0]};
         BYTES_TWO:   result_in = {16'd0, scaled[15:0]};
         BYTES_THREE: result_in = {8'd0, scaled[23:0]};
         BYTES_FOUR:  result_in = scaled;
         default:     result_in = s1_sample_ff;  // raw passthrough
      endcase
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         result_ff <= result_in;
         last_ff   <= s1_last_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.sample_out = result_ff;
   assign rsp_chan.last_out   = last_ff;

endmodule
